>>> src/f8q_pkg.sv
// Package: saturation code constant for the FP32 to E4M3 quantizer.
`default_nettype none
package f8q_pkg;
  localparam logic [6:0] SAT_CODE = 7'h7E;
endpackage
`default_nettype wire

>>> src/fp32_to_fp8_e4m3_quantizer_unit.sv
// Top level: FP32 to E4M3 quantizer with decode of the result code.
//
// Channel   Direction  Signals                        Handshake
// request   in         float_bits                     start & !busy
// result    out        fp8_code, dequant_bits         done strobe, one cycle
//
// One request per cycle. A request passes through the input register, then
// the result register; done rises as the result is registered.
// busy is held low: the encode and decode logic between the registers
// keeps pace with any request stream.
// rst clears the valid flags of both stages; data registers are not reset.
// The receiver cannot stall, so nothing is held back.
`default_nettype none
module fp32_to_fp8_e4m3_quantizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] float_bits,
  output logic             done,
  output logic [7:0]       fp8_code,
  output logic [31:0]      dequant_bits
);

  logic        in_vld;
  logic [31:0] in_bits;
  logic [7:0]  code_next;
  logic [31:0] deq_next;

  assign busy = 1'b0;

  // capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start;
    end
    in_bits <= float_bits;
  end

  // encode
  logic       sgn;
  logic [7:0] ex;
  logic [22:0] frac;
  logic [23:0] sig;
  logic [4:0]  sh;
  logic [24:0] q_sub, rem_sub, half_sub, mask_sub;
  logic [3:0]  m_sub;
  logic [3:0]  m_nrm;
  logic [4:0]  ee;
  logic [19:0] rem_n;
  always_comb begin
    sgn  = in_bits[31];
    ex   = in_bits[30:23];
    frac = in_bits[22:0];
    sig  = {1'b1, frac};
    sh   = 5'(8'd141 - ex);
    // one spare bit keeps the half-step mark for the largest shift
    q_sub    = {1'b0, sig} >> sh;
    mask_sub = (25'd1 << sh) - 25'd1;
    rem_sub  = {1'b0, sig} & mask_sub;
    half_sub = 25'd1 << (sh - 5'd1);
    m_sub = q_sub[3:0];
    if (rem_sub > half_sub || (rem_sub == half_sub && q_sub[0]))
      m_sub = m_sub + 4'd1;
    rem_n = frac[19:0];
    m_nrm = {1'b0, frac[22:20]};
    if (rem_n > 20'h80000 || (rem_n == 20'h80000 && frac[20]))
      m_nrm = m_nrm + 4'd1;
    ee = 5'(ex - 8'd120);
    if (m_nrm[3]) begin
      m_nrm = 4'd0;
      ee = ee + 5'd1;
    end
    if (ex == 8'd0 && frac == 23'd0) begin
      code_next = 8'h00;
    end else if (ex < 8'd116) begin
      code_next = {sgn, 7'd0};
    end else if (ex < 8'd121) begin
      code_next = {sgn, 3'd0, m_sub};
    end else if (ex > 8'd135 || ee > 5'd15 || (ee == 5'd15 && m_nrm == 4'd7)) begin
      code_next = {sgn, f8q_pkg::SAT_CODE};
    end else begin
      code_next = {sgn, ee[3:0], m_nrm[2:0]};
    end
  end

  // decode
  logic [3:0] de;
  logic [2:0] dm;
  always_comb begin
    de = code_next[6:3];
    dm = code_next[2:0];
    if (de == 4'd0) begin
      if (dm == 3'd0)
        deq_next = {code_next[7], 31'd0};
      else if (dm[2])
        deq_next = {code_next[7], 8'd120, dm[1:0], 21'd0};
      else if (dm[1])
        deq_next = {code_next[7], 8'd119, dm[0], 22'd0};
      else
        deq_next = {code_next[7], 8'd118, 23'd0};
    end else if (de == 4'd15 && dm == 3'd7) begin
      deq_next = {code_next[7], 8'd135, 3'd6, 20'd0};
    end else begin
      deq_next = {code_next[7], 8'(de) + 8'd120, dm, 20'd0};
    end
  end

  // register result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
    fp8_code     <= code_next;
    dequant_bits <= deq_next;
  end

  // checks
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_vld |=> done) else $error("result strobe missing");
  a_no_bad_code: assert property (@(posedge clk) disable iff (rst)
    done |-> fp8_code[6:0] != 7'h7F) else $error("E4M3 NaN code produced");
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (done && fp8_code == 8'h00) |-> dequant_bits == 32'd0)
    else $error("zero decode wrong");
endmodule
`default_nettype wire
